@@ src/edva_pkg.sv @@
// types, codes and the step table shared by the encoder detent value adjuster
// no dependencies
package edva_pkg;

  typedef logic signed [1:0] detent_t;
  typedef logic signed [31:0] value_t;
  typedef logic [1:0] pins_t;
  typedef logic [19:0] step_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_ADJUST = 1'b1;

  localparam detent_t DETENT_NONE = 2'sd0;
  localparam detent_t DETENT_CW   = 2'sd1;
  localparam detent_t DETENT_CCW  = -2'sd1;

  localparam value_t RANGE_1 = 32'sd10000;
  localparam value_t RANGE_2 = 32'sd100000;
  localparam value_t RANGE_3 = 32'sd1000000;

  // control from the top level to the quadrature decoder
  typedef struct packed {
    logic  step;    // an item leaves the input register this cycle
    logic  sample;  // that item is a pin sample
    pins_t pins;    // decoded pins, bit set when the pin is low, a in bit 1
  } quad_ctrl_t;

  // step for base range sel (1000 times 10^sel) at digit offset k (divide by 10^k)
  function automatic step_t step_amount(input logic [1:0] sel, input logic [1:0] k);
    logic [2:0] e;
    step_t r;
    e = 3'd3 + {1'b0, sel} - {1'b0, k};
    case (e)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      3'd6: r = 20'd1000000;
      default: r = 20'd1;
    endcase
    return r;
  endfunction

endpackage

@@ src/edva_if.sv @@
// valid/ready channels for requests and results of the detent value adjuster
// depends on edva_pkg
interface edva_req_if;
  import edva_pkg::*;
  logic   valid;
  logic   ready;
  logic   req_type;
  logic   pin_left;
  logic   pin_right;
  logic [2:0] digit_index;
  value_t value_in;
  value_t upper_limit;
  value_t lower_limit;

  modport source(output valid, req_type, pin_left, pin_right, digit_index, value_in,
                 upper_limit, lower_limit, input ready);
  modport sink(input valid, req_type, pin_left, pin_right, digit_index, value_in,
               upper_limit, lower_limit, output ready);
endinterface

interface edva_rsp_if;
  import edva_pkg::*;
  logic    valid;
  logic    ready;
  detent_t detent;
  value_t  value_out;

  modport source(output valid, detent, value_out, input ready);
  modport sink(input valid, detent, value_out, output ready);
endinterface

@@ src/edva_quad.sv @@
// full-cycle quadrature state machine holding the pending detent
// depends on edva_pkg
module edva_quad
  import edva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  quad_ctrl_t ctrl,
  output detent_t    pending,
  output detent_t    detent_next
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_BOTH  = 2'd2;
  localparam logic [1:0] PH_LAST  = 2'd3;

  pins_t      prev_pins, prev_pins_next;
  logic [1:0] phase, phase_next;
  detent_t    direction, direction_next;

  always_comb begin
    prev_pins_next = prev_pins;
    phase_next     = phase;
    direction_next = direction;
    detent_next    = DETENT_NONE;
    if (ctrl.sample && ctrl.pins != prev_pins) begin
      prev_pins_next = ctrl.pins;
      unique case (phase)
        PH_IDLE: begin
          if (prev_pins == 2'b00 && ctrl.pins == 2'b10) begin
            direction_next = DETENT_CW;
            phase_next     = PH_FIRST;
          end else if (prev_pins == 2'b00 && ctrl.pins == 2'b01) begin
            direction_next = DETENT_CCW;
            phase_next     = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (ctrl.pins == 2'b11) begin
            phase_next = PH_BOTH;
          end else begin
            phase_next     = PH_IDLE;
            direction_next = DETENT_NONE;
          end
        end
        PH_BOTH: begin
          if ((direction == DETENT_CW && ctrl.pins == 2'b01) ||
              (direction == DETENT_CCW && ctrl.pins == 2'b10)) begin
            phase_next = PH_LAST;
          end else begin
            phase_next     = PH_IDLE;
            direction_next = DETENT_NONE;
          end
        end
        PH_LAST: begin
          if (ctrl.pins == 2'b00) begin
            detent_next = direction;
          end
          phase_next     = PH_IDLE;
          direction_next = DETENT_NONE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins <= 2'b00;
      phase     <= PH_IDLE;
      direction <= DETENT_NONE;
      pending   <= DETENT_NONE;
    end else if (ctrl.step) begin
      prev_pins <= prev_pins_next;
      phase     <= phase_next;
      direction <= direction_next;
      // adjust items consume the detent, samples replace it
      pending   <= detent_next;
    end
  end

endmodule

@@ src/encoder_detent_value_adjuster_unit.sv @@
// top level: input register, quadrature decoder, clamped value adjust, result register
// depends on edva_pkg, edva_if, edva_quad
// Items pass the input register, then the result register; one item is accepted every
// cycle unless result.ready stalls the output: the quadrature state and pending detent
// update as an item leaves the input register, so the next item already sees them. A
// sample item decodes the active-low pins and reports the detent it completed; an
// adjust item steps value_in by a power of ten chosen by digit_index and the range of
// value_in toward the pending detent, clamps it to the limits and reports a detent of
// 0. Between the registers: a step table lookup, a 34-bit add or subtract, compares.
module encoder_detent_value_adjuster_unit
  import edva_pkg::*;
(
  input logic clk,
  input logic rst,
  edva_req_if.sink   request,
  edva_rsp_if.source result
);

  logic       s1_valid;
  logic       s1_type;
  pins_t      s1_pins;
  logic [2:0] s1_digit;
  value_t     s1_value;
  value_t     s1_upper;
  value_t     s1_lower;
  logic       s1_move;

  logic    out_valid;
  detent_t out_detent;
  value_t  out_value;

  quad_ctrl_t qctrl;
  detent_t    pending;
  detent_t    detent_next;

  assign s1_move       = s1_valid && (!out_valid || result.ready);
  assign request.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_type  <= request.req_type;
      s1_pins  <= {~request.pin_left, ~request.pin_right};
      s1_digit <= request.digit_index;
      s1_value <= request.value_in;
      s1_upper <= request.upper_limit;
      s1_lower <= request.lower_limit;
    end
  end

  assign qctrl.step   = s1_move;
  assign qctrl.sample = (s1_type == REQ_SAMPLE);
  assign qctrl.pins   = s1_pins;

  edva_quad u_quad (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (qctrl),
    .pending     (pending),
    .detent_next (detent_next)
  );

  // adjust path
  logic [1:0]        base_sel;
  logic              digit_ok;
  logic [1:0]        digit_ofs;
  logic signed [33:0] step_w;
  logic signed [33:0] value_w;
  logic signed [33:0] upper_w;
  logic signed [33:0] lower_w;
  logic signed [33:0] moved_w;
  value_t            adjusted;

  always_comb begin
    if (s1_value < RANGE_1) begin
      base_sel = 2'd0;
    end else if (s1_value < RANGE_2) begin
      base_sel = 2'd1;
    end else if (s1_value < RANGE_3) begin
      base_sel = 2'd2;
    end else begin
      base_sel = 2'd3;
    end
    digit_ok  = (s1_digit >= 3'd1) && (s1_digit <= 3'd4);
    digit_ofs = 2'(s1_digit - 3'd1);
    step_w    = $signed({14'd0, step_amount(base_sel, digit_ofs)});
    value_w   = 34'(s1_value);
    upper_w   = 34'(s1_upper);
    lower_w   = 34'(s1_lower);
    moved_w   = value_w;
    if (digit_ok) begin
      if (s1_value < s1_upper && pending > 2'sd0) begin
        moved_w = value_w + step_w;
      end else if (s1_value > s1_lower && pending < 2'sd0) begin
        moved_w = value_w - step_w;
      end
    end
    if (moved_w > upper_w) begin
      adjusted = s1_upper;
    end else if (moved_w < lower_w) begin
      adjusted = s1_lower;
    end else begin
      adjusted = moved_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_detent <= detent_next;
      out_value  <= (s1_type == REQ_ADJUST) ? adjusted : s1_value;
    end
  end

  assign result.valid     = out_valid;
  assign result.detent    = out_detent;
  assign result.value_out = out_value;

endmodule
